### src/hough_accumulator_peak_finder_assert.svh
// assertion helpers, clocked on clk and disabled during reset
`ifndef HOUGH_ACCUMULATOR_PEAK_FINDER_ASSERT_SVH
`define HOUGH_ACCUMULATOR_PEAK_FINDER_ASSERT_SVH

// same-cycle implication
`define HAP_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HAP_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/hap_pkg.sv
package hap_pkg;

	localparam int HAP_BINS_A     = 64;
	localparam int HAP_BINS_B     = 64;
	localparam int HAP_COUNT_BITS = 16;
	localparam int HAP_MAX_PEAKS  = 64;

	typedef enum logic [2:0] {
		CFG_MIN_A     = 3'd0,
		CFG_MIN_B     = 3'd1,
		CFG_RES_A     = 3'd2,
		CFG_RES_B     = 3'd3,
		CFG_INV_RES_A = 3'd4,
		CFG_INV_RES_B = 3'd5,
		CFG_RANGE_A   = 3'd6,
		CFG_RANGE_B   = 3'd7
	} cfg_idx_t;

	typedef enum logic {
		MODE_VOTE    = 1'b0,
		MODE_EXTRACT = 1'b1
	} mode_t;

	// binner result status
	typedef struct packed {
		logic done;
		logic hit;
	} bin_stat_t;

	// window steps, center first
	localparam int NBR_STEPS = 9;
	localparam logic signed [1:0] STEP_DA [NBR_STEPS] =
		'{2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1};
	localparam logic signed [1:0] STEP_DB [NBR_STEPS] =
		'{2'sd0, -2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd1};

endpackage

### src/hap_if.sv
interface hap_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] coord_a;
	logic [31:0] coord_b;
	logic [15:0] threshold;

	modport source (output valid, mode, coord_a, coord_b, threshold, input ready);
	modport sink   (input valid, mode, coord_a, coord_b, threshold, output ready);
endinterface

interface hap_rsp_if;
	logic        valid;
	logic        ready;
	logic        valid_res;
	logic [31:0] cell_a;
	logic [31:0] cell_b;
	logic [15:0] votes;
	logic        truncated;
	logic        last;

	modport source (output valid, valid_res, cell_a, cell_b, votes, truncated, last,
		input ready);
	modport sink   (input valid, valid_res, cell_a, cell_b, votes, truncated, last,
		output ready);
endinterface

### src/hough_accumulator_peak_finder.sv
// Hough voting store of BINS_A x BINS_B saturating counts in one memory with a
// single read and a single write port. After reset a clearing pass writes zero to
// all 2**(clog2(BINS_A)+clog2(BINS_B)) words, one per cycle, before the first
// transfer is taken; configuration writes are taken throughout. A vote transfer
// runs through difference, reciprocal multiply, rounding and range check,
// memory read, and increment and write back before the next transfer is taken;
// a vote that falls outside the range is dropped without the write back.
// An extract transfer scans the effective range row-major and reads the 3x3
// window of each bin through the one read port, then hands on the final result,
// which closes the run. Results leave through an output register, so the scan
// stalls only while it is full.
module hough_accumulator_peak_finder #(
	parameter int BINS_A     = hap_pkg::HAP_BINS_A,
	parameter int BINS_B     = hap_pkg::HAP_BINS_B,
	parameter int COUNT_BITS = hap_pkg::HAP_COUNT_BITS,
	parameter int MAX_PEAKS  = hap_pkg::HAP_MAX_PEAKS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  hap_pkg::cfg_idx_t cfg_idx,
	input  logic [31:0]       cfg_wdata,
	hap_req_if.sink           req,
	hap_rsp_if.source         rsp
);

	import hap_pkg::*;

	localparam int IA = (BINS_A > 1) ? $clog2(BINS_A) : 1;
	localparam int IB = (BINS_B > 1) ? $clog2(BINS_B) : 1;
	localparam int AW = IA + IB;
	localparam int NW = $clog2(MAX_PEAKS + 1);

	typedef enum logic [7:0] {
		ST_CLR  = 8'b0000_0001,
		ST_IDLE = 8'b0000_0010,
		ST_VOTE = 8'b0000_0100,
		ST_VWR  = 8'b0000_1000,
		ST_SCAN = 8'b0001_0000,
		ST_FIN  = 8'b0010_0000,
		ST_NEXT = 8'b0100_0000,
		ST_END  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [31:0] min_a_q, min_b_q, res_a_q, res_b_q, inv_a_q, inv_b_q;
	logic [5:0]  range_a_q, range_b_q;
	logic [IA-1:0] ea;
	logic [IB-1:0] eb;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_a_q   <= 32'd0;
			min_b_q   <= 32'd0;
			res_a_q   <= 32'd65536;
			res_b_q   <= 32'd65536;
			inv_a_q   <= 32'd65536;
			inv_b_q   <= 32'd65536;
			range_a_q <= 6'd63;
			range_b_q <= 6'd63;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_MIN_A:     min_a_q   <= cfg_wdata;
				CFG_MIN_B:     min_b_q   <= cfg_wdata;
				CFG_RES_A:     res_a_q   <= cfg_wdata;
				CFG_RES_B:     res_b_q   <= cfg_wdata;
				CFG_INV_RES_A: inv_a_q   <= cfg_wdata;
				CFG_INV_RES_B: inv_b_q   <= cfg_wdata;
				CFG_RANGE_A:   range_a_q <= cfg_wdata[5:0];
				CFG_RANGE_B:   range_b_q <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	assign ea = (32'(range_a_q) < 32'(BINS_A - 1)) ? IA'(range_a_q) : IA'(BINS_A - 1);
	assign eb = (32'(range_b_q) < 32'(BINS_B - 1)) ? IB'(range_b_q) : IB'(BINS_B - 1);

	// vote binning
	bin_stat_t     bstat;
	logic [AW-1:0] baddr;
	logic          req_xfer;

	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;

	hap_binner #(.IA(IA), .IB(IB)) u_binner (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (req_xfer && (req.mode == MODE_VOTE)),
		.coord_a (req.coord_a),
		.coord_b (req.coord_b),
		.min_a   (min_a_q),
		.min_b   (min_b_q),
		.inv_a   (inv_a_q),
		.inv_b   (inv_b_q),
		.ea      (ea),
		.eb      (eb),
		.stat    (bstat),
		.addr    (baddr)
	);

	// count store
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

	hap_ram #(.WIDTH(COUNT_BITS), .DEPTH(2 ** AW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic [AW-1:0] clr_q, vaddr_q;
	logic [IA-1:0] a_q;
	logic [IB-1:0] b_q;
	logic [3:0]    k_q;
	logic [15:0]   thr_q;
	logic          rdv_s1, ctr_s1;
	logic [COUNT_BITS-1:0] c_q;
	logic          fail_q, fail_now, peak_now;
	logic [NW-1:0] n_q;

	// window addressing
	logic signed [1:0] da, db;
	logic [IA-1:0] na;
	logic [IB-1:0] nb;
	logic          nbr_in;

	always_comb begin
		da = STEP_DA[k_q];
		db = STEP_DB[k_q];
		na = a_q;
		nb = b_q;
		if (da < 0) begin
			na = a_q - IA'(1);
		end else if (da > 0) begin
			na = a_q + IA'(1);
		end
		if (db < 0) begin
			nb = b_q - IB'(1);
		end else if (db > 0) begin
			nb = b_q + IB'(1);
		end
		nbr_in = !((da < 0) && (a_q == '0)) && !((da > 0) && (a_q == ea)) &&
			!((db < 0) && (b_q == '0)) && !((db > 0) && (b_q == eb));
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = vaddr_q;
		ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
		ram_raddr = {na, nb};
		if (state_q == ST_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == ST_VWR) begin
			ram_we = 1'b1;
		end
		if (state_q == ST_VOTE) begin
			ram_raddr = baddr;
		end
	end

	// window compare on returned data
	always_comb begin
		fail_now = 1'b0;
		if (rdv_s1) begin
			if (ctr_s1) begin
				fail_now = 32'(ram_rdata) < 32'(thr_q);
			end else begin
				fail_now = ram_rdata >= c_q;
			end
		end
		peak_now = !(fail_q || fail_now);
	end

	// cell centers
	logic [32+IA-1:0]  prod_a_q;
	logic [32+IB-1:0]  prod_b_q;
	logic signed [63:0] sum_a, sum_b;
	logic [31:0]       cell_a, cell_b;
	logic [31:0]       c32;

	always_ff @(posedge clk) begin
		prod_a_q <= (32+IA)'(res_a_q) * (32+IA)'(a_q);
		prod_b_q <= (32+IB)'(res_b_q) * (32+IB)'(b_q);
	end

	assign sum_a  = $signed({{32{min_a_q[31]}}, min_a_q}) + $signed(64'(prod_a_q));
	assign sum_b  = $signed({{32{min_b_q[31]}}, min_b_q}) + $signed(64'(prod_b_q));
	assign cell_a = (sum_a > 64'sd2147483647) ? 32'h7FFF_FFFF : sum_a[31:0];
	assign cell_b = (sum_b > 64'sd2147483647) ? 32'h7FFF_FFFF : sum_b[31:0];
	assign c32    = 32'(c_q);

	logic        peak_q;
	logic [31:0] new_a_q, new_b_q, pend_a_q, pend_b_q;
	logic [15:0] new_v_q, pend_v_q;

	// output register
	logic        o_valid_q, o_vr_q, o_tr_q, o_last_q;
	logic [31:0] o_a_q, o_b_q;
	logic [15:0] o_v_q;
	logic        out_free;

	assign out_free = !o_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			o_valid_q <= 1'b0;
			rdv_s1    <= 1'b0;
			ctr_s1    <= 1'b0;
			fail_q    <= 1'b0;
			peak_q    <= 1'b0;
			n_q       <= '0;
			k_q       <= '0;
			a_q       <= '0;
			b_q       <= '0;
		end else begin
			if (o_valid_q && rsp.ready) begin
				o_valid_q <= 1'b0;
			end
			rdv_s1 <= 1'b0;
			fail_q <= fail_q || fail_now;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_xfer) begin
						if (req.mode == MODE_EXTRACT) begin
							a_q     <= '0;
							b_q     <= '0;
							k_q     <= '0;
							n_q     <= '0;
							fail_q  <= 1'b0;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_VOTE;
						end
					end
				end
				ST_VOTE: begin
					if (bstat.done) begin
						state_q <= bstat.hit ? ST_VWR : ST_IDLE;
					end
				end
				ST_VWR: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					rdv_s1 <= nbr_in;
					ctr_s1 <= (k_q == '0);
					if (k_q == 4'(NBR_STEPS - 1)) begin
						k_q     <= '0;
						state_q <= ST_FIN;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				ST_FIN: begin
					peak_q  <= peak_now;
					fail_q  <= 1'b0;
					k_q     <= '0;
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (!peak_q || n_q == '0 || out_free) begin
						if (peak_q && n_q == NW'(MAX_PEAKS)) begin
							o_valid_q <= 1'b1;
							o_tr_q    <= 1'b1;
							o_last_q  <= 1'b1;
							n_q       <= '0;
							state_q   <= ST_IDLE;
						end else begin
							if (peak_q) begin
								if (n_q != '0) begin
									o_valid_q <= 1'b1;
									o_tr_q    <= 1'b0;
									o_last_q  <= 1'b0;
								end
								n_q <= n_q + NW'(1);
							end
							if (b_q == eb) begin
								b_q <= '0;
								if (a_q == ea) begin
									state_q <= ST_END;
								end else begin
									a_q     <= a_q + IA'(1);
									state_q <= ST_SCAN;
								end
							end else begin
								b_q     <= b_q + IB'(1);
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_END: begin
					if (out_free) begin
						o_valid_q <= 1'b1;
						o_tr_q    <= 1'b0;
						o_last_q  <= 1'b1;
						n_q       <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_VOTE && bstat.done) begin
			vaddr_q <= baddr;
		end
		if (state_q == ST_IDLE && req_xfer) begin
			thr_q <= req.threshold;
		end
		if (rdv_s1 && ctr_s1) begin
			c_q <= ram_rdata;
		end
		if (state_q == ST_FIN) begin
			new_a_q <= cell_a;
			new_b_q <= cell_b;
			new_v_q <= (c32 > 32'h0000_FFFF) ? 16'hFFFF : c32[15:0];
		end
		if (state_q == ST_NEXT && peak_q && n_q != '0 && out_free) begin
			o_vr_q <= 1'b1;
			o_a_q  <= pend_a_q;
			o_b_q  <= pend_b_q;
			o_v_q  <= pend_v_q;
		end
		if (state_q == ST_NEXT && peak_q && (n_q == '0 || out_free) &&
			n_q != NW'(MAX_PEAKS)) begin
			pend_a_q <= new_a_q;
			pend_b_q <= new_b_q;
			pend_v_q <= new_v_q;
		end
		if (state_q == ST_END && out_free) begin
			o_vr_q <= (n_q != '0);
			o_a_q  <= (n_q != '0) ? pend_a_q : 32'd0;
			o_b_q  <= (n_q != '0) ? pend_b_q : 32'd0;
			o_v_q  <= (n_q != '0) ? pend_v_q : 16'd0;
		end
	end

	assign rsp.valid     = o_valid_q;
	assign rsp.valid_res = o_vr_q;
	assign rsp.cell_a    = o_a_q;
	assign rsp.cell_b    = o_b_q;
	assign rsp.votes     = o_v_q;
	assign rsp.truncated = o_tr_q;
	assign rsp.last      = o_last_q;

`include "hough_accumulator_peak_finder_assert.svh"

	`HAP_CHECK(a_ram_write_owner, ram_we, (state_q == ST_CLR) || (state_q == ST_VWR), "stray write")
	`HAP_CHECK(a_binner_done_in_vote, bstat.done, state_q == ST_VOTE, "stray binner result")
	`HAP_CHECK(a_trunc_is_last, rsp.valid && rsp.truncated, rsp.last, "truncated not last")
	`HAP_CHECK(a_empty_result, rsp.valid && !rsp.valid_res, rsp.last && (rsp.votes == 16'd0), "bad empty")
	`HAP_CHECK_NEXT(a_fin_after_scan, state_q == ST_FIN, state_q == ST_NEXT, "fin not followed by next")

endmodule

### src/hap_ram.sv
module hap_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/hap_binner.sv
module hap_binner #(
	parameter int IA = 6,
	parameter int IB = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         coord_a,
	input  logic [31:0]         coord_b,
	input  logic [31:0]         min_a,
	input  logic [31:0]         min_b,
	input  logic [31:0]         inv_a,
	input  logic [31:0]         inv_b,
	input  logic [IA-1:0]       ea,
	input  logic [IB-1:0]       eb,
	output hap_pkg::bin_stat_t  stat,
	output logic [IA+IB-1:0]    addr
);

	import hap_pkg::*;

	logic        vld_s1, vld_s2, vld_s3;
	logic [32:0] da_s1, db_s1;
	logic        neg_s2;
	logic [63:0] pa_s2, pb_s2;
	logic        hit_s3;
	logic [IA+IB-1:0] addr_s3;
	logic [64:0] sum_a, sum_b;
	logic [32:0] bin_a, bin_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// exact difference
	always_ff @(posedge clk) begin
		da_s1 <= {coord_a[31], coord_a} - {min_a[31], min_a};
		db_s1 <= {coord_b[31], coord_b} - {min_b[31], min_b};
	end

	// scale by reciprocal
	always_ff @(posedge clk) begin
		neg_s2 <= da_s1[32] | db_s1[32];
		pa_s2  <= 64'(da_s1[31:0]) * 64'(inv_a);
		pb_s2  <= 64'(db_s1[31:0]) * 64'(inv_b);
	end

	// round half up and range check
	assign sum_a = 65'(pa_s2) + 65'(33'h0_8000_0000);
	assign sum_b = 65'(pb_s2) + 65'(33'h0_8000_0000);
	assign bin_a = sum_a[64:32];
	assign bin_b = sum_b[64:32];

	always_ff @(posedge clk) begin
		hit_s3  <= !neg_s2 && (bin_a <= 33'(ea)) && (bin_b <= 33'(eb));
		addr_s3 <= {bin_a[IA-1:0], bin_b[IB-1:0]};
	end

	assign stat.done = vld_s3;
	assign stat.hit  = hit_s3;
	assign addr      = addr_s3;

endmodule
